// ===== hw/rtl/mode_window_schedule_table_macros.svh =====
// Assertion shorthands for the checker in mwst_checker.sv.
`ifndef MODE_WINDOW_SCHEDULE_TABLE_MACROS_SVH
`define MODE_WINDOW_SCHEDULE_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MWST_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MWST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mwst_pkg.sv =====
package mwst_pkg;

  typedef enum logic {
    CMD_SCHEDULE = 1'b0,
    CMD_QUERY    = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_REVERSED = 2'd1,
    STAT_FULL     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PUSH
  } back_state_e;

  // Classification bits the front attaches to every queued item.
  typedef struct packed {
    cmd_e cmd;
    logic reversed;
    logic mode;
  } ctl_t;

  localparam int unsigned CTL_BITS = $bits(ctl_t);

  // One result item.
  typedef struct packed {
    status_e    status;
    logic [3:0] slot;
    logic       active;
    logic [4:0] total;
  } res_t;

endpackage

// ===== hw/rtl/mwst_front.sv =====
module mwst_front #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                                      in_valid_i,
  output logic                                      in_stall_o,
  input  logic                                      command_i,
  input  logic [TIME_BITS-1:0]                      window_start_time_i,
  input  logic [TIME_BITS-1:0]                      window_end_time_i,
  input  logic                                      window_mode_i,
  input  logic [TIME_BITS-1:0]                      query_time_i,
  output logic                                      push_o,
  input  logic                                      full_i,
  output logic [mwst_pkg::CTL_BITS+2*TIME_BITS-1:0] data_o
);
  import mwst_pkg::*;

  ctl_t                 ctl;
  logic [TIME_BITS-1:0] t_first;

  // Classify: flag a reversed window here so the back only tests the flag and the fill level.
  always_comb begin
    ctl.cmd      = cmd_e'(command_i);
    ctl.reversed = (window_end_time_i < window_start_time_i);
    ctl.mode     = window_mode_i;
    // A query carries its tick in the start slot.
    t_first      = (ctl.cmd == CMD_QUERY) ? query_time_i : window_start_time_i;
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;
  assign data_o     = {ctl, t_first, window_end_time_i};

endmodule

// ===== hw/rtl/mwst_queue.sv =====
module mwst_queue #(
  parameter int unsigned WIDTH = 99
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       fill_q, fill_d;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign full_o  = fill_q[1];
  assign valid_o = (fill_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

endmodule

// ===== hw/rtl/mwst_back.sv =====
module mwst_back #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned TIME_BITS   = 48
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      q_valid_i,
  input  logic [mwst_pkg::CTL_BITS+2*TIME_BITS-1:0] q_data_i,
  output logic                                      q_pop_o,
  output logic                                      out_valid_o,
  input  logic                                      out_stall_i,
  output mwst_pkg::res_t                            res_o
);
  import mwst_pkg::*;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

  logic [TIME_BITS-1:0] start_mem [TABLE_DEPTH];
  logic [TIME_BITS-1:0] end_mem   [TABLE_DEPTH];
  logic                 mode_mem  [TABLE_DEPTH];

  back_state_e          state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     rem_q, rem_d;
  logic [IDX_W-1:0]     addr_q, addr_d;
  logic                 pend_q, pend_d;
  logic                 out_vld_q, out_vld_d;
  logic [TIME_BITS-1:0] qtime_q, qtime_d;
  res_t                 res_q, res_d;
  res_t                 out_q, out_d;
  logic [TIME_BITS-1:0] rd_start_q, rd_end_q;
  logic                 rd_mode_q;

  ctl_t                 ctl;
  logic [TIME_BITS-1:0] t_first, t_second;
  logic [CNT_W-1:0]     cnt_inc;
  logic                 wr_en;
  logic                 hit;

  assign {ctl, t_first, t_second} = q_data_i;
  assign cnt_inc = count_q + CNT_W'(1);
  assign hit     = (qtime_q >= rd_start_q) && (qtime_q <= rd_end_q);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    rem_d     = rem_q;
    addr_d    = addr_q;
    pend_d    = 1'b0;
    qtime_d   = qtime_q;
    res_d     = res_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;
    wr_en     = 1'b0;
    q_pop_o   = 1'b0;

    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o      = 1'b1;
          res_d.status = STAT_OK;
          res_d.slot   = 4'd0;
          res_d.active = 1'b0;
          res_d.total  = 5'(count_q);
          if (ctl.cmd == CMD_SCHEDULE) begin
            priority if (ctl.reversed) begin
              res_d.status = STAT_REVERSED;
            end else if (count_q == CNT_FULL) begin
              res_d.status = STAT_FULL;
            end else begin
              wr_en       = 1'b1;
              res_d.slot  = 4'(count_q);
              res_d.total = 5'(cnt_inc);
              count_d     = cnt_inc;
            end
            state_d = ST_PUSH;
          end else begin
            // Start the scan at the newest window.
            qtime_d = t_first;
            rem_d   = count_q;
            addr_d  = IDX_W'(count_q - CNT_W'(1));
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        priority if (pend_q && hit) begin
          res_d.active = rd_mode_q;
          state_d      = ST_PUSH;
        end else if (rem_q == '0) begin
          res_d.active = 1'b1;
          state_d      = ST_PUSH;
        end else begin
          pend_d = 1'b1;
          rem_d  = rem_q - CNT_W'(1);
          addr_d = addr_q - IDX_W'(1);
        end
      end
      ST_PUSH: begin
        if (!out_vld_q || !out_stall_i) begin
          out_vld_d = 1'b1;
          out_d     = res_q;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      rem_q     <= '0;
      addr_q    <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rem_q     <= rem_d;
      addr_q    <= addr_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qtime_q <= qtime_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  // Window table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      start_mem[count_q[IDX_W-1:0]] <= t_first;
      end_mem[count_q[IDX_W-1:0]]   <= t_second;
      mode_mem[count_q[IDX_W-1:0]]  <= ctl.mode;
    end
    rd_start_q <= start_mem[addr_q];
    rd_end_q   <= end_mem[addr_q];
    rd_mode_q  <= mode_mem[addr_q];
  end

  assign out_valid_o = out_vld_q;
  assign res_o       = out_q;

endmodule

// ===== hw/rtl/mode_window_schedule_table.sv =====
// Mode window schedule table.
// Input channel (in_valid_i / in_stall_o) carries one command per transfer:
// command_i = 0 appends the window [window_start_time_i, window_end_time_i]
// with window_mode_i, command_i = 1 asks the mode at query_time_i.
// Output channel (out_valid_o / out_stall_i) returns exactly one result per
// command, in order: status_o, slot_index_o, is_active_o, window_total_o.
// A command is registered in the queue, then in the back end's result
// register, then in the output register; a query scans the table in
// between, checking windows until one covers the tick (all stored ones
// when none does). The table has one read port and is scanned newest to
// oldest, one entry per cycle, stopping at the first hit. One item is
// worked on at a time; a two-entry queue in front lets up to two further
// commands be taken while the back end scans or waits.
// Reset clears the window count and all handshake state; table contents
// stay unknown but only written slots are ever used for a result.
// When the receiver stalls, the result holds on the output ports, the
// back end waits, and the queue fills until in_stall_o rises.
module mode_window_schedule_table #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned TIME_BITS   = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 command_i,
  input  logic [TIME_BITS-1:0] window_start_time_i,
  input  logic [TIME_BITS-1:0] window_end_time_i,
  input  logic                 window_mode_i,
  input  logic [TIME_BITS-1:0] query_time_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           status_o,
  output logic [3:0]           slot_index_o,
  output logic                 is_active_o,
  output logic [4:0]           window_total_o
);
  import mwst_pkg::*;

  localparam int unsigned ENTRY_W = CTL_BITS + 2 * TIME_BITS;

  logic               push;
  logic               full;
  logic [ENTRY_W-1:0] push_data;
  logic               q_valid;
  logic               q_pop;
  logic [ENTRY_W-1:0] q_data;
  res_t               res;

  // Front: classify and enqueue.
  mwst_front #(
    .TIME_BITS(TIME_BITS)
  ) u_front (
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .window_start_time_i(window_start_time_i),
    .window_end_time_i  (window_end_time_i),
    .window_mode_i      (window_mode_i),
    .query_time_i       (query_time_i),
    .push_o             (push),
    .full_i             (full),
    .data_o             (push_data)
  );

  // Decoupling queue between front and back.
  mwst_queue #(
    .WIDTH(ENTRY_W)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .full_o (full),
    .valid_o(q_valid),
    .pop_i  (q_pop),
    .data_o (q_data)
  );

  // Back: table update, scan and output register.
  mwst_back #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .TIME_BITS  (TIME_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (q_data),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (res)
  );

  assign status_o       = res.status;
  assign slot_index_o   = res.slot;
  assign is_active_o    = res.active;
  assign window_total_o = res.total;

endmodule

// ===== hw/rtl/mwst_checker.sv =====
`include "mode_window_schedule_table_macros.svh"

module mwst_checker #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] status_o,
  input logic [3:0] slot_index_o,
  input logic       is_active_o,
  input logic [4:0] window_total_o
);
  import mwst_pkg::*;

  `MWST_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(status_o) && $stable(window_total_o) && $stable(is_active_o), "result changed while stalled")

  `MWST_ASSERT_IMPL(a_status_code, clk_i, rst_ni, out_valid_o, status_o == STAT_OK || status_o == STAT_REVERSED || status_o == STAT_FULL, "undefined status code")

  `MWST_ASSERT_IMPL(a_reject_clean, clk_i, rst_ni, out_valid_o && status_o != STAT_OK, slot_index_o == 4'd0 && is_active_o == 1'b0, "rejected window carries slot or mode")

  `MWST_ASSERT_IMPL(a_full_total, clk_i, rst_ni, out_valid_o && status_o == STAT_FULL, window_total_o == 5'(TABLE_DEPTH), "table full reported below capacity")

endmodule

bind mode_window_schedule_table mwst_checker #(
  .TABLE_DEPTH(TABLE_DEPTH)
) u_mwst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_o      (status_o),
  .slot_index_o  (slot_index_o),
  .is_active_o   (is_active_o),
  .window_total_o(window_total_o)
);

// ===== dv/tb_mode_window_schedule_table.sv =====
module tb_mode_window_schedule_table;
  timeunit 1ns;
  timeprecision 1ps;

  import mwst_pkg::*;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned TICK_W     = 48;
  localparam int          RAND_ITEMS = 480;
  // No transfer on either channel for this many cycles means the block hangs.
  localparam int          IDLE_LIMIT = 3000;
  // Receiver hold-off long enough to back the queue up into in_stall_o.
  localparam int          LONG_HOLD  = 400;
  localparam int          DRAIN_WAIT = 40;

  typedef logic [TICK_W-1:0] tick_t;

  // One command as it travels over the input channel.
  typedef struct {
    cmd_e  cmd;
    tick_t start_t;
    tick_t end_t;
    logic  mode;
    tick_t query_t;
  } sched_cmd_t;

  logic       clk_i               = 1'b0;
  logic       rst_ni              = 1'b0;
  logic       in_valid_i          = 1'b0;
  logic       in_stall_o;
  logic       command_i           = 1'b0;
  tick_t      window_start_time_i = '0;
  tick_t      window_end_time_i   = '0;
  logic       window_mode_i       = 1'b0;
  tick_t      query_time_i        = '0;
  logic       out_valid_o;
  logic       out_stall_i         = 1'b0;
  logic [1:0] status_o;
  logic [3:0] slot_index_o;
  logic       is_active_o;
  logic [4:0] window_total_o;

  mode_window_schedule_table uut (.*);

  // Commands waiting to be offered, and replies waiting to come back.
  sched_cmd_t cmd_backlog[$];
  res_t       pending_replies[$];

  // Shadow copy of the window table, advanced at each accepted input transfer.
  tick_t tbl_start[DEPTH];
  tick_t tbl_end[DEPTH];
  logic  tbl_mode[DEPTH];
  int    tbl_count = 0;

  int  fail_count   = 0;
  int  replies_seen = 0;
  bit  in_took      = 1'b0;

  // Windows handed to the stimulus so far, used to aim queries at edges.
  tick_t aim_start[$];
  tick_t aim_end[$];
  tick_t anchors[4];

  // Apply one command to the shadow table and return the reply it earns.
  function automatic res_t apply_table_cmd(sched_cmd_t c);
    res_t r;
    int   k;
    bit   hit;
    r.status = STAT_OK;
    r.slot   = '0;
    r.active = 1'b0;
    hit      = 1'b0;
    if (c.cmd == CMD_SCHEDULE) begin
      if (c.end_t < c.start_t) begin
        r.status = STAT_REVERSED;
      end else if (tbl_count >= DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        r.slot = tbl_count[3:0];
        tbl_start[tbl_count] = c.start_t;
        tbl_end[tbl_count]   = c.end_t;
        tbl_mode[tbl_count]  = c.mode;
        tbl_count++;
      end
    end else begin
      // Newest containing window decides; nothing covering means active.
      r.active = 1'b1;
      for (k = tbl_count - 1; k >= 0; k--) begin
        if (!hit && c.query_t >= tbl_start[k] && c.query_t <= tbl_end[k]) begin
          r.active = tbl_mode[k];
          hit      = 1'b1;
        end
      end
    end
    r.total = tbl_count[4:0];
    return r;
  endfunction

  function automatic tick_t rand_tick();
    return tick_t'({$urandom(), $urandom()});
  endfunction

  task automatic add_window(tick_t t0, tick_t t1, logic m);
    sched_cmd_t c;
    c.cmd     = CMD_SCHEDULE;
    c.start_t = t0;
    c.end_t   = t1;
    c.mode    = m;
    c.query_t = rand_tick();
    cmd_backlog.push_back(c);
    aim_start.push_back(t0);
    aim_end.push_back(t1);
  endtask

  task automatic add_query(tick_t t);
    sched_cmd_t c;
    c.cmd     = CMD_QUERY;
    c.start_t = rand_tick();
    c.end_t   = rand_tick();
    c.mode    = 1'($urandom_range(0, 1));
    c.query_t = t;
    cmd_backlog.push_back(c);
  endtask

  // Random window near one of the anchor ticks, now and then reversed or
  // spread over the whole tick range.
  task automatic add_random_window();
    tick_t t0;
    tick_t t1;
    int    pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      t0 = rand_tick();
      t1 = rand_tick();
    end else begin
      t0 = anchors[$urandom_range(0, 3)] + tick_t'($urandom_range(0, 300));
      if (pick < 22) t1 = t0 - tick_t'($urandom_range(1, 50));
      else           t1 = t0 + tick_t'($urandom_range(0, 120));
    end
    add_window(t0, t1, 1'($urandom_range(0, 1)));
  endtask

  // Random query: often at or beside an edge (or the middle) of a known window, else near an anchor or anywhere.
  task automatic add_random_query();
    tick_t t;
    int    pick;
    int    w;
    pick = $urandom_range(0, 99);
    if (pick < 55 && aim_start.size() > 0) begin
      w = $urandom_range(0, aim_start.size() - 1);
      case ($urandom_range(0, 4))
        0: t = aim_start[w] - 1'b1;
        1: t = aim_start[w];
        2: t = aim_end[w];
        3: t = aim_end[w] + 1'b1;
        default: t = aim_start[w] + ((aim_end[w] - aim_start[w]) >> 1);
      endcase
    end else if (pick < 80) begin
      t = anchors[$urandom_range(0, 3)] + tick_t'($urandom_range(0, 450));
    end else begin
      t = rand_tick();
    end
    add_query(t);
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Stimulus, reset and end of run.
  initial begin
    int    i;
    tick_t tmax;
    tmax       = '1;
    anchors[0] = '0;
    anchors[1] = tmax - tick_t'(500);
    anchors[2] = rand_tick() >> 1;
    anchors[3] = {1'b1, {(TICK_W - 1){1'b0}}} - tick_t'(250);

    // Empty table: everything reads as active.
    add_query('0);
    add_query(tmax);
    // Reversed windows are turned away, including the widest reversal.
    add_window(tick_t'(1), '0, 1'b0);
    add_window(tmax, '0, 1'b1);
    // Single-tick windows at both ends of the tick range.
    add_window('0, '0, 1'b0);
    add_query('0);
    add_query(tick_t'(1));
    add_window(tmax, tmax, 1'b0);
    add_query(tmax);
    add_query(tmax - 1'b1);
    // Full-range window overrides everything older.
    add_window('0, tmax, 1'b1);
    add_query('0);
    add_query(tmax);
    // Nested windows: the newer inner one wins inside, the outer one around it.
    add_window(tick_t'(100), tick_t'(200), 1'b0);
    add_query(tick_t'(99));
    add_query(tick_t'(100));
    add_query(tick_t'(200));
    add_query(tick_t'(201));
    add_window(tick_t'(150), tick_t'(160), 1'b1);
    add_query(tick_t'(155));
    add_query(tick_t'(170));

    // Random part: schedules fill the table, then full and reversed
    // rejections mix with queries against the full table.
    for (i = 0; i < RAND_ITEMS; i++) begin
      if ($urandom_range(0, 99) < 25) add_random_window();
      else                            add_random_query();
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait until every command went over and every reply came back; look at
    // the rising edge, where the sender's last offer is already visible.
    do begin
      @(posedge clk_i);
    end while (cmd_backlog.size() > 0 || in_valid_i || pending_replies.size() > 0);
    // Allow stray replies to show up.
    repeat (DRAIN_WAIT) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Sender: offer commands in bursts with random gaps; hold a stalled transfer.
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk_i) begin
    sched_cmd_t c;
    if (rst_ni && !(in_valid_i && !in_took)) begin
      if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left--;
      end else if (cmd_backlog.size() > 0) begin
        c = cmd_backlog.pop_front();
        command_i           <= c.cmd;
        window_start_time_i <= c.start_t;
        window_end_time_i   <= c.end_t;
        window_mode_i       <= c.mode;
        query_time_i        <= c.query_t;
        in_valid_i          <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Input side: record each transfer and predict its reply.
  always @(posedge clk_i) begin
    sched_cmd_t c;
    in_took = rst_ni && in_valid_i && !in_stall_o;
    if (in_took) begin
      c.cmd     = cmd_e'(command_i);
      c.start_t = window_start_time_i;
      c.end_t   = window_end_time_i;
      c.mode    = window_mode_i;
      c.query_t = query_time_i;
      pending_replies.push_back(apply_table_cmd(c));
    end
  end

  // Receiver: stall in segments of differing character, plus one long hold.
  int  hold_left  = 0;
  bit  hold_done  = 1'b0;
  int  seg_left   = 0;
  int  seg_kind   = 0;
  int  seg_phase  = 0;

  always @(negedge clk_i) begin
    if (!hold_done && replies_seen >= 60) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      if (seg_left == 0) begin
        seg_kind  = $urandom_range(0, 3);
        seg_left  = $urandom_range(10, 60);
        seg_phase = 0;
      end
      seg_left--;
      seg_phase++;
      case (seg_kind)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 9) < 4);
        2: out_stall_i <= (seg_phase % 3 == 0);
        default: out_stall_i <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  // Output side: compare each reply with the oldest prediction.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      replies_seen++;
      if (pending_replies.size() == 0) begin
        $error("unexpected reply: status %0d slot %0d active %0d total %0d",
               status_o, slot_index_o, is_active_o, window_total_o);
        fail_count++;
      end else begin
        want = pending_replies.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fail_count++;
        end
        if (slot_index_o !== want.slot) begin
          $error("slot_index: expected %0d, got %0d", want.slot, slot_index_o);
          fail_count++;
        end
        if (is_active_o !== want.active) begin
          $error("is_active: expected %0d, got %0d", want.active, is_active_o);
          fail_count++;
        end
        if (window_total_o !== want.total) begin
          $error("window_total: expected %0d, got %0d", want.total, window_total_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule
